@@ rtl/core/rcfd_pkg.sv @@
// Package: shared types, constants and helpers for the remote-control frame decoder.
`timescale 1ns / 1ps
package rcfd_pkg;

  localparam int unsigned FrameBytesDef = 18;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 12;

  localparam logic [CfgIdxW-1:0] CfgStickOffset = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStickRange  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSwUp        = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSwMid       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSwDown      = 3'd4;

  localparam logic [2:0] SwUp      = 3'd0;
  localparam logic [2:0] SwMid     = 3'd1;
  localparam logic [2:0] SwDown    = 3'd2;
  localparam logic [2:0] SwUpMid   = 3'd3;
  localparam logic [2:0] SwMidDown = 3'd4;
  localparam logic [2:0] SwDownMid = 3'd5;
  localparam logic [2:0] SwMidUp   = 3'd6;

  // dividend magnitude is |diff| * 65536 (27 bits), divisor 12 bits
  localparam int unsigned DivNumW = 27;
  localparam int unsigned DivDenW = 12;
  localparam int unsigned NumSticks = 5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_wheel;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [2:0]         left_switch_status;
    logic [2:0]         right_switch_status;
    logic [3:0]         mouse_button_status;
    logic [31:0]        key_status;
  } frame_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StDivide,
    StStore,
    StOut
  } ctrl_state_e;

  typedef struct packed {
    logic load_stick;   // latch the next stick channel into the divider
    logic div_step;     // one restoring-division step
    logic store_stick;  // write the finished quotient
    logic finish;       // build the result word and update history
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_stick;
  } dp_stat_t;

  typedef struct packed {
    logic [10:0] stick_offset;
    logic [11:0] stick_range;
    logic [1:0]  sw_up;
    logic [1:0]  sw_mid;
    logic [1:0]  sw_down;
  } cfg_t;

  function automatic logic [1:0] key_class(input logic now, input logic prev);
    logic [1:0] r;
    if (!prev) r = now ? 2'd2 : 2'd0;
    else       r = now ? 2'd1 : 2'd3;
    return r;
  endfunction

  function automatic logic [1:0] sw_clean(input logic [1:0] c, input cfg_t cfg);
    logic [1:0] r;
    if (c == cfg.sw_up || c == cfg.sw_mid || c == cfg.sw_down) r = c;
    else r = cfg.sw_mid;
    return r;
  endfunction

  function automatic logic [2:0] sw_class(input logic [1:0] now_raw,
                                          input logic [1:0] prev_raw,
                                          input cfg_t cfg);
    logic [1:0] now_c;
    logic [1:0] prev_c;
    logic [2:0] r;
    now_c  = sw_clean(now_raw, cfg);
    prev_c = sw_clean(prev_raw, cfg);
    if (prev_c == cfg.sw_up) begin
      if (now_c == cfg.sw_up) r = SwUp;
      else if (now_c == cfg.sw_mid) r = SwUpMid;
      else r = SwMidDown;
    end else if (prev_c == cfg.sw_down) begin
      if (now_c == cfg.sw_down) r = SwDown;
      else if (now_c == cfg.sw_mid) r = SwDownMid;
      else r = SwMidUp;
    end else if (now_c == cfg.sw_up) begin
      r = SwMidUp;
    end else if (now_c == cfg.sw_down) begin
      r = SwMidDown;
    end else begin
      r = SwMid;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/rcfd_stream_if.sv @@
// Interface: valid/ready channel carrying one payload word.
`timescale 1ns / 1ps
interface rcfd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rcfd_ctrl.sv @@
// Controller: sequences the five stick divisions and the result build.
`timescale 1ns / 1ps
module rcfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              out_free_i,
  input  rcfd_pkg::dp_stat_t stat_i,
  output rcfd_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);

  rcfd_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rcfd_pkg::StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcfd_pkg::StIdle:   if (start_i) state_d = rcfd_pkg::StLoad;
      rcfd_pkg::StLoad:   state_d = rcfd_pkg::StDivide;
      rcfd_pkg::StDivide: if (stat_i.div_done) state_d = rcfd_pkg::StStore;
      rcfd_pkg::StStore: begin
        if (stat_i.last_stick) state_d = rcfd_pkg::StOut;
        else                   state_d = rcfd_pkg::StLoad;
      end
      rcfd_pkg::StOut:    if (out_free_i) state_d = rcfd_pkg::StIdle;
      default:            state_d = rcfd_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      rcfd_pkg::StIdle:   busy_o = 1'b0;
      rcfd_pkg::StLoad:   cmd_o.load_stick = 1'b1;
      rcfd_pkg::StDivide: cmd_o.div_step = 1'b1;
      rcfd_pkg::StStore:  cmd_o.store_stick = 1'b1;
      rcfd_pkg::StOut:    cmd_o.finish = out_free_i;
      default:            busy_o = 1'b1;
    endcase
  end

endmodule

@@ rtl/core/rcfd_datapath.sv @@
// Datapath: frame store, byte counting, serial divider and result register.
`timescale 1ns / 1ps
module rcfd_datapath #(
  parameter int unsigned FrameBytes = rcfd_pkg::FrameBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcfd_pkg::cfg_t     cfg_i,
  input  logic               in_fire_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               chunk_last_i,
  output logic               start_o,
  input  rcfd_pkg::dp_cmd_t  cmd_i,
  output rcfd_pkg::dp_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_free_o,
  output logic [16*8-1:0]    axes_o,
  output logic [2:0]         left_sw_o,
  output logic [2:0]         right_sw_o,
  output logic [3:0]         buttons_o,
  output logic [31:0]        keys_o
);

  localparam int unsigned CntW = $clog2(FrameBytes + 1);
  localparam int unsigned IdxW = $clog2(FrameBytes);
  localparam int unsigned StepW = $clog2(rcfd_pkg::DivNumW + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FrameBytes);

  logic [7:0]      store_q [FrameBytes];
  logic [CntW-1:0] cnt_q;

  // frame store and count
  always_ff @(posedge clk_i) begin
    if (in_fire_i && cnt_q < FullCnt) store_q[cnt_q[IdxW-1:0]] <= rx_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_fire_i) begin
      if (chunk_last_i) cnt_q <= '0;
      else if (cnt_q < FullCnt) cnt_q <= cnt_q + 1'b1;
    end
  end

  // frame completes when the closing byte lands in or beyond the last slot
  assign start_o = in_fire_i && chunk_last_i && (cnt_q >= FullCnt - 1'b1);

  // stick channel unpack; bytes are static while the sequence runs
  logic [10:0] ch [rcfd_pkg::NumSticks];
  always_comb begin
    ch[0] = {store_q[1][2:0], store_q[0]};
    ch[1] = {store_q[2][5:0], store_q[1][7:3]};
    ch[2] = {store_q[4][0], store_q[3], store_q[2][7:6]};
    ch[3] = {store_q[5][3:0], store_q[4][7:1]};
    ch[4] = {store_q[17][2:0], store_q[16]};
  end

  logic [2:0] sel_q;
  logic [2:0] sel_d;
  logic [rcfd_pkg::DivNumW-1:0] num_q, num_d;
  logic [rcfd_pkg::DivDenW:0]   rem_q, rem_d;
  logic [StepW-1:0]             step_q, step_d;
  logic                         neg_q, neg_d;
  logic [15:0]                  stick_q [rcfd_pkg::NumSticks];

  logic signed [11:0] diff;
  logic [10:0]        mag;
  logic [rcfd_pkg::DivDenW-1:0] den;
  logic [rcfd_pkg::DivDenW:0]   trial;
  logic [rcfd_pkg::DivDenW:0]   shifted;
  logic [15:0]                  sat;

  always_comb begin
    diff = $signed({1'b0, ch[sel_q]}) - $signed({1'b0, cfg_i.stick_offset});
    mag  = diff[11] ? 11'(-diff) : diff[10:0];
    den  = (cfg_i.stick_range == '0) ? 12'd1 : cfg_i.stick_range;
    shifted = {rem_q[rcfd_pkg::DivDenW-1:0], num_q[rcfd_pkg::DivNumW-1]};
    trial   = shifted - {1'b0, den};
    // quotient magnitude saturation; quotient holds in num_q
    if (neg_q) sat = (num_q > 27'd32768) ? 16'h8000 : 16'(-num_q[15:0]);
    else       sat = (num_q > 27'd32767) ? 16'h7FFF : num_q[15:0];
  end

  always_comb begin
    sel_d  = sel_q;
    num_d  = num_q;
    rem_d  = rem_q;
    step_d = step_q;
    neg_d  = neg_q;
    if (start_o) sel_d = '0;
    if (cmd_i.load_stick) begin
      num_d  = {mag, 16'd0};
      rem_d  = '0;
      step_d = '0;
      neg_d  = diff[11];
    end
    if (cmd_i.div_step) begin
      if (!trial[rcfd_pkg::DivDenW]) begin
        rem_d = trial;
        num_d = {num_q[rcfd_pkg::DivNumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[rcfd_pkg::DivNumW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
    end
    if (cmd_i.store_stick) sel_d = sel_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      step_q <= '0;
    end else begin
      sel_q  <= sel_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    if (cmd_i.store_stick) stick_q[sel_q] <= sat;
  end

  assign stat_o.div_done   = cmd_i.div_step &&
                             (step_q == StepW'(rcfd_pkg::DivNumW - 1));
  assign stat_o.last_stick = (sel_q == 3'(rcfd_pkg::NumSticks - 1));

  // result register and history
  logic [1:0]  prev_l_q, prev_r_q, prev_b_q;
  logic [15:0] prev_k_q;
  logic        ov_q;
  logic [1:0]  s1, s2;
  logic        bl, br;
  logic [15:0] keys;
  logic [31:0] ks;

  always_comb begin
    s1   = store_q[5][7:6];
    s2   = store_q[5][5:4];
    bl   = store_q[12] != 8'd0;
    br   = store_q[13] != 8'd0;
    keys = {store_q[15], store_q[14]};
    for (int i = 0; i < 16; i++) ks[2*i +: 2] = rcfd_pkg::key_class(keys[i], prev_k_q[i]);
  end

  assign out_free_o = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q     <= 1'b0;
      prev_l_q <= '0;
      prev_r_q <= '0;
      prev_b_q <= '0;
      prev_k_q <= '0;
    end else begin
      if (cmd_i.finish) begin
        ov_q     <= 1'b1;
        prev_l_q <= s1;
        prev_r_q <= s2;
        prev_b_q <= {br, bl};
        prev_k_q <= keys;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      axes_o <= {stick_q[0], stick_q[1], stick_q[2], stick_q[3], stick_q[4],
                 store_q[7], store_q[6], store_q[9], store_q[8],
                 store_q[11], store_q[10]};
      left_sw_o  <= rcfd_pkg::sw_class(s1, prev_l_q, cfg_i);
      right_sw_o <= rcfd_pkg::sw_class(s2, prev_r_q, cfg_i);
      buttons_o  <= {rcfd_pkg::key_class(br, prev_b_q[1]),
                     rcfd_pkg::key_class(bl, prev_b_q[0])};
      keys_o     <= ks;
    end
  end

  assign out_valid_o = ov_q;

endmodule

@@ rtl/core/rc_frame_decode_edge_classify.sv @@
// Top level: remote-control frame decoder with switch/button/key edge classification.
// Throughput: one byte per cycle while idle; ready stays low while a frame is decoded,
// and longer while the previous result word has not been taken.
// The decode time is set by the bit-serial divider shared by the five stick channels.
// Reset (rst_ni, async low) clears byte count, history, output valid and loads default config.
`timescale 1ns / 1ps
module rc_frame_decode_edge_classify #(
  parameter int unsigned FrameBytes = rcfd_pkg::FrameBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rcfd_pkg::CfgDataW-1:0]  cfg_data_i,
  rcfd_stream_if.sink                    in_if,
  rcfd_stream_if.source                  out_if
);

  rcfd_pkg::cfg_t     cfg_q;
  rcfd_pkg::dp_cmd_t  cmd;
  rcfd_pkg::dp_stat_t stat;
  logic               busy, start, in_fire, out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_offset <= 11'd1024;
      cfg_q.stick_range  <= 12'd1320;
      cfg_q.sw_up        <= 2'd1;
      cfg_q.sw_mid       <= 2'd3;
      cfg_q.sw_down      <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcfd_pkg::CfgStickOffset: cfg_q.stick_offset <= cfg_data_i[10:0];
        rcfd_pkg::CfgStickRange:  cfg_q.stick_range  <= cfg_data_i[11:0];
        rcfd_pkg::CfgSwUp:        cfg_q.sw_up        <= cfg_data_i[1:0];
        rcfd_pkg::CfgSwMid:       cfg_q.sw_mid       <= cfg_data_i[1:0];
        rcfd_pkg::CfgSwDown:      cfg_q.sw_down      <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !busy;
  assign in_fire     = in_if.valid && !busy;

  rcfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  rcfd_datapath #(.FrameBytes(FrameBytes)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_fire_i    (in_fire),
    .rx_byte_i    (in_if.data.rx_byte),
    .chunk_last_i (in_if.data.chunk_last),
    .start_o      (start),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_free_o   (out_free),
    .axes_o       ({out_if.data.right_x, out_if.data.right_y, out_if.data.left_x,
                    out_if.data.left_y, out_if.data.left_wheel, out_if.data.mouse_x,
                    out_if.data.mouse_y, out_if.data.mouse_z}),
    .left_sw_o    (out_if.data.left_switch_status),
    .right_sw_o   (out_if.data.right_switch_status),
    .buttons_o    (out_if.data.mouse_button_status),
    .keys_o       (out_if.data.key_status)
  );

endmodule

@@ tb/tb.sv @@
// Testbench for the remote-control frame decoder: random chunks checked against a local predictor.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned NBytes = rcfd_pkg::FrameBytesDef;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned Drain = 200;

  typedef rcfd_pkg::in_word_t    in_word_t;
  typedef rcfd_pkg::frame_word_t frame_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rcfd_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [rcfd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  rcfd_stream_if #(.payload_t(in_word_t)) in_ch ();
  rcfd_stream_if #(.payload_t(frame_word_t)) out_ch ();

  rc_frame_decode_edge_classify dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_ch), .out_if(out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of config and history
  rcfd_pkg::cfg_t pcfg;
  logic [7:0]  fstore [NBytes];
  int unsigned nkept;
  logic [1:0]  hist_lsw, hist_rsw, hist_btn;
  logic [15:0] hist_keys;

  in_word_t    pending_words[$];
  frame_word_t expected_frames[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0, out_gap = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [15:0] norm_stick(input logic [10:0] ch);
    longint diff, den, q;
    diff = longint'(ch) - longint'(pcfg.stick_offset);
    den = (pcfg.stick_range == 0) ? 1 : longint'(pcfg.stick_range);
    q = (diff * 65536) / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [1:0] clean_sw(input logic [1:0] c);
    if (c == pcfg.sw_up || c == pcfg.sw_mid || c == pcfg.sw_down) return c;
    return pcfg.sw_mid;
  endfunction

  function automatic logic [2:0] classify_sw(input logic [1:0] now_raw,
                                             input logic [1:0] prev_raw);
    logic [1:0] n, p;
    n = clean_sw(now_raw);
    p = clean_sw(prev_raw);
    if (p == pcfg.sw_up) return (n == pcfg.sw_up) ? rcfd_pkg::SwUp :
                                (n == pcfg.sw_mid) ? rcfd_pkg::SwUpMid : rcfd_pkg::SwMidDown;
    if (p == pcfg.sw_down) return (n == pcfg.sw_down) ? rcfd_pkg::SwDown :
                                  (n == pcfg.sw_mid) ? rcfd_pkg::SwDownMid : rcfd_pkg::SwMidUp;
    if (n == pcfg.sw_up) return rcfd_pkg::SwMidUp;
    if (n == pcfg.sw_down) return rcfd_pkg::SwMidDown;
    return rcfd_pkg::SwMid;
  endfunction

  function automatic logic [1:0] classify_bit(input logic now, input logic prev);
    if (!prev) return now ? 2'd2 : 2'd0;
    return now ? 2'd1 : 2'd3;
  endfunction

  task automatic decode_word(input in_word_t w);
    frame_word_t f;
    logic [10:0] ch [5];
    logic [1:0]  s1, s2;
    logic        bl, br;
    logic [15:0] keys;
    if (nkept < NBytes) begin
      fstore[nkept] = w.rx_byte;
      nkept++;
    end
    if (w.chunk_last) begin
      if (nkept >= NBytes) begin
        ch[0] = {fstore[1][2:0], fstore[0]};
        ch[1] = {fstore[2][5:0], fstore[1][7:3]};
        ch[2] = {fstore[4][0], fstore[3], fstore[2][7:6]};
        ch[3] = {fstore[5][3:0], fstore[4][7:1]};
        ch[4] = {fstore[17][2:0], fstore[16]};
        s1 = fstore[5][7:6];
        s2 = fstore[5][5:4];
        bl = fstore[12] != 0;
        br = fstore[13] != 0;
        keys = {fstore[15], fstore[14]};
        f.right_x = norm_stick(ch[0]);
        f.right_y = norm_stick(ch[1]);
        f.left_x = norm_stick(ch[2]);
        f.left_y = norm_stick(ch[3]);
        f.left_wheel = norm_stick(ch[4]);
        f.mouse_x = {fstore[7], fstore[6]};
        f.mouse_y = {fstore[9], fstore[8]};
        f.mouse_z = {fstore[11], fstore[10]};
        f.left_switch_status = classify_sw(s1, hist_lsw);
        f.right_switch_status = classify_sw(s2, hist_rsw);
        f.mouse_button_status = {classify_bit(br, hist_btn[1]), classify_bit(bl, hist_btn[0])};
        for (int i = 0; i < 16; i++)
          f.key_status[2*i +: 2] = classify_bit(keys[i], hist_keys[i]);
        hist_lsw = s1;
        hist_rsw = s2;
        hist_btn = {br, bl};
        hist_keys = keys;
        expected_frames.push_back(f);
      end
      nkept = 0;
    end
  endtask

  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
  endfunction

  // byte driver; predicts on each accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) decode_word(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_ch.data <= pending_words.pop_front();
          in_ch.valid <= 1'b1;
          in_gap <= draw_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    frame_word_t e, a;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        if (expected_frames.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          e = expected_frames.pop_front();
          check_field("right_x", e.right_x, a.right_x);
          check_field("right_y", e.right_y, a.right_y);
          check_field("left_x", e.left_x, a.left_x);
          check_field("left_y", e.left_y, a.left_y);
          check_field("left_wheel", e.left_wheel, a.left_wheel);
          check_field("mouse_x", e.mouse_x, a.mouse_x);
          check_field("mouse_y", e.mouse_y, a.mouse_y);
          check_field("mouse_z", e.mouse_z, a.mouse_z);
          check_field("left_switch_status", e.left_switch_status, a.left_switch_status);
          check_field("right_switch_status", e.right_switch_status, a.right_switch_status);
          check_field("mouse_button_status", e.mouse_button_status, a.mouse_button_status);
          check_field("key_status", e.key_status, a.key_status);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid) out_gap <= draw_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[rc_frame_decode_edge_classify] ERROR");
      $finish;
    end
  end

  task automatic queue_chunk(input int unsigned len, input int fill);
    in_word_t w;
    for (int unsigned i = 0; i < len; i++) begin
      if (fill >= 0) w.rx_byte = fill[7:0];
      else if ((i == 12 || i == 13) && $urandom_range(0, 1)) w.rx_byte = 8'h00;
      else w.rx_byte = 8'($urandom_range(0, 255));
      w.chunk_last = (i == len - 1);
      pending_words.push_back(w);
    end
  endtask

  task automatic write_reg(input logic [rcfd_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[rcfd_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rcfd_pkg::CfgStickOffset: pcfg.stick_offset = val[10:0];
      rcfd_pkg::CfgStickRange:  pcfg.stick_range = val[11:0];
      rcfd_pkg::CfgSwUp:        pcfg.sw_up = val[1:0];
      rcfd_pkg::CfgSwMid:       pcfg.sw_mid = val[1:0];
      default:                  pcfg.sw_down = val[1:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_ch.valid || expected_frames.size() > 0)
      @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned nbytes);
    int unsigned sent, len, r;
    sent = 0;
    while (sent < nbytes) begin
      r = $urandom_range(0, 9);
      if (r < 7) len = NBytes;
      else if (r < 9) len = $urandom_range(1, NBytes - 1);
      else len = $urandom_range(NBytes + 1, NBytes + 6);
      queue_chunk(len, -1);
      sent += len;
    end
  endtask

  initial begin
    pcfg = '{stick_offset: 11'd1024, stick_range: 12'd1320,
             sw_up: 2'd1, sw_mid: 2'd3, sw_down: 2'd2};
    nkept = 0;
    hist_lsw = '0;
    hist_rsw = '0;
    hist_btn = '0;
    hist_keys = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zeros, ones, short and long chunk, back-to-back frames
    queue_chunk(NBytes, 0);
    queue_chunk(NBytes, 255);
    queue_chunk(5, 255);
    queue_chunk(NBytes + 3, 0);
    queue_chunk(1, 0);
    queue_chunk(NBytes, -1);
    wait_idle();
    random_phase(340);
    wait_idle();

    write_reg(rcfd_pkg::CfgStickOffset, 0);
    write_reg(rcfd_pkg::CfgStickRange, 4095);
    write_reg(rcfd_pkg::CfgSwUp, 0);
    write_reg(rcfd_pkg::CfgSwMid, 1);
    write_reg(rcfd_pkg::CfgSwDown, 3);
    random_phase(340);
    wait_idle();

    // zero range saturates; all switch codes collide
    write_reg(rcfd_pkg::CfgStickOffset, 2047);
    write_reg(rcfd_pkg::CfgStickRange, 0);
    write_reg(rcfd_pkg::CfgSwUp, 2);
    write_reg(rcfd_pkg::CfgSwMid, 2);
    write_reg(rcfd_pkg::CfgSwDown, 2);
    random_phase(200);
    wait_idle();

    write_reg(rcfd_pkg::CfgStickRange, 1);
    write_reg(rcfd_pkg::CfgSwUp, 3);
    write_reg(rcfd_pkg::CfgSwMid, 0);
    write_reg(rcfd_pkg::CfgSwDown, 3);
    random_phase(200);
    wait_idle();

    write_reg(rcfd_pkg::CfgStickOffset, $urandom_range(0, 2047));
    write_reg(rcfd_pkg::CfgStickRange, $urandom_range(1, 4095));
    write_reg(rcfd_pkg::CfgSwUp, $urandom_range(0, 3));
    write_reg(rcfd_pkg::CfgSwMid, $urandom_range(0, 3));
    write_reg(rcfd_pkg::CfgSwDown, $urandom_range(0, 3));
    random_phase(340);
    wait_idle();

    write_reg(rcfd_pkg::CfgStickOffset, 1024);
    write_reg(rcfd_pkg::CfgStickRange, 1320);
    write_reg(rcfd_pkg::CfgSwUp, 1);
    write_reg(rcfd_pkg::CfgSwMid, 3);
    write_reg(rcfd_pkg::CfgSwDown, 2);
    random_phase(200);
    wait_idle();

    if (errors == 0) $display("[rc_frame_decode_edge_classify] OK");
    else $display("[rc_frame_decode_edge_classify] ERROR");
    $finish;
  end
endmodule
